// ===== rtl/core/x128_pkg.sv =====
// ----------------------------------------------------------------------------
// x128_pkg
// shared types and constants of the xorshift128 generator
// ----------------------------------------------------------------------------
package x128_pkg;

   localparam int unsigned WORD_W = 32;

   // recurrence shift amounts
   localparam int unsigned SHIFT_A = 11;
   localparam int unsigned SHIFT_D = 19;
   localparam int unsigned SHIFT_T = 8;

   typedef enum logic {
      ACTION_NEXT   = 1'b0,
      ACTION_RESEED = 1'b1
   } action_type;

   // load strobe from the state stage into the result register
   typedef struct packed {
      logic              load;
      logic [WORD_W-1:0] value;
   } rsp_load_type;

endpackage

// ===== rtl/core/x128_if.sv =====
// ----------------------------------------------------------------------------
// x128 channel interfaces
// valid/ready channels for requests and random values
// ----------------------------------------------------------------------------
interface x128_req_if;
   logic                        valid;
   logic                        ready;
   logic                        action;
   logic [x128_pkg::WORD_W-1:0] seed;

   modport source (output valid, output action, output seed, input ready);
   modport sink (input valid, input action, input seed, output ready);
endinterface

interface x128_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [x128_pkg::WORD_W-1:0] random_value;

   modport source (output valid, output random_value, input ready);
   modport sink (input valid, input random_value, output ready);
endinterface

// ===== rtl/core/x128_state.sv =====
// ----------------------------------------------------------------------------
// x128_state
// generator state words, one step or reseed per accepted transaction
// ----------------------------------------------------------------------------
module x128_state #(
   parameter logic [31:0] DEFAULT_A = 32'd123456789,
   parameter logic [31:0] DEFAULT_B = 32'd362436069,
   parameter logic [31:0] DEFAULT_C = 32'd521288629,
   parameter logic [31:0] DEFAULT_D = 32'd88675123
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic                        action,
   input  logic [x128_pkg::WORD_W-1:0] seed,
   output x128_pkg::rsp_load_type      load
);

   logic [x128_pkg::WORD_W-1:0] word_a_ff, word_b_ff, word_c_ff, word_d_ff;
   logic [x128_pkg::WORD_W-1:0] word_a_in, word_b_in, word_c_in, word_d_in;
   logic [x128_pkg::WORD_W-1:0] t_val, d_next;
   logic [15:0]                 even_nib, odd_nib;
   logic                        is_reseed;

   assign is_reseed = (x128_pkg::action_type'(action) == x128_pkg::ACTION_RESEED);

   // one recurrence step
   assign t_val  = word_a_ff ^ (word_a_ff << x128_pkg::SHIFT_A);
   assign d_next = (word_d_ff ^ (word_d_ff >> x128_pkg::SHIFT_D))
                 ^ (t_val ^ (t_val >> x128_pkg::SHIFT_T));

   // seed expansion: even and odd nibbles, lowest nibble first
   assign even_nib = {seed[27:24], seed[19:16], seed[11:8], seed[3:0]};
   assign odd_nib  = {seed[31:28], seed[23:20], seed[15:12], seed[7:4]};

   always_comb begin
      word_a_in = word_a_ff;
      word_b_in = word_b_ff;
      word_c_in = word_c_ff;
      word_d_in = word_d_ff;
      if (accept) begin
         if (!is_reseed) begin
            word_a_in = word_b_ff;
            word_b_in = word_c_ff;
            word_c_in = word_d_ff;
            word_d_in = d_next;
         end else if (seed == '0) begin
            word_a_in = DEFAULT_A;
            word_b_in = DEFAULT_B;
            word_c_in = DEFAULT_C;
            word_d_in = DEFAULT_D;
         end else begin
            word_a_in = seed;
            word_b_in = {seed[15:0], seed[31:16]};
            word_c_in = {odd_nib, even_nib};
            word_d_in = {even_nib, odd_nib};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_a_ff <= DEFAULT_A;
         word_b_ff <= DEFAULT_B;
         word_c_ff <= DEFAULT_C;
         word_d_ff <= DEFAULT_D;
      end else begin
         word_a_ff <= word_a_in;
         word_b_ff <= word_b_in;
         word_c_ff <= word_c_in;
         word_d_ff <= word_d_in;
      end
   end

   assign load.load  = accept && !is_reseed;
   assign load.value = d_next;

endmodule

// ===== rtl/core/x128_out.sv =====
// ----------------------------------------------------------------------------
// x128_out
// result register in front of the response channel
// ----------------------------------------------------------------------------
module x128_out (
   input  logic                   clock,
   input  logic                   reset,
   input  x128_pkg::rsp_load_type load,
   output logic                   space,
   x128_rsp_if.source             rsp
);

   logic                        valid_ff, valid_in;
   logic [x128_pkg::WORD_W-1:0] value_ff;

   // free when empty or being emptied this cycle
   assign space = !valid_ff || rsp.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load.load) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load.load) begin
         value_ff <= load.value;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.random_value = value_ff;

endmodule

// ===== rtl/core/xorshift128_generator.sv =====
// ----------------------------------------------------------------------------
// xorshift128_generator
// xorshift128 random number source with seed expansion
// ----------------------------------------------------------------------------
// Each request transaction either steps the generator (action next), giving one
// 32-bit random value on the response channel, or reseeds it (action reseed),
// giving nothing. A nonzero seed is expanded into the four state words; a zero
// seed restores the DEFAULT_ words, as reset does. One transaction is taken per
// clock while the result register has room: the step is a few shifts and xors
// between the state words and the result register, so the value appears in the
// cycle after acceptance. The only thing that holds requests back is a full
// result register whose value the response side is not taking.
module xorshift128_generator #(
   parameter logic [31:0] DEFAULT_A = 32'd123456789,
   parameter logic [31:0] DEFAULT_B = 32'd362436069,
   parameter logic [31:0] DEFAULT_C = 32'd521288629,
   parameter logic [31:0] DEFAULT_D = 32'd88675123
) (
   input logic        clock,
   input logic        reset,
   x128_req_if.sink   req_bus,
   x128_rsp_if.source rsp_bus
);

   x128_pkg::rsp_load_type load;
   logic                   space;
   logic                   accept;

   // every transaction waits for room; a reseed simply leaves the register as is
   assign req_bus.ready = space;
   assign accept        = req_bus.valid && space;

   // state words and step logic
   x128_state #(
      .DEFAULT_A (DEFAULT_A),
      .DEFAULT_B (DEFAULT_B),
      .DEFAULT_C (DEFAULT_C),
      .DEFAULT_D (DEFAULT_D)
   ) u_state (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .action (req_bus.action),
      .seed   (req_bus.seed),
      .load   (load)
   );

   // result register towards the response channel
   x128_out u_out (
      .clock (clock),
      .reset (reset),
      .load  (load),
      .space (space),
      .rsp   (rsp_bus)
   );

endmodule

// ===== rtl/core/x128_checker.sv =====
// ----------------------------------------------------------------------------
// x128_checker
// port-level checks of the xorshift128 generator
// ----------------------------------------------------------------------------
module x128_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_action,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [x128_pkg::WORD_W-1:0] rsp_value
);

   logic req_take, next_take, reseed_take;

   assign req_take    = req_valid && req_ready;
   assign next_take   = req_take
                     && (x128_pkg::action_type'(req_action) == x128_pkg::ACTION_NEXT);
   assign reseed_take = req_take
                     && (x128_pkg::action_type'(req_action) == x128_pkg::ACTION_RESEED);

   // nothing pending after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a step always shows a value in the next cycle
   a_next_result: assert property (@(posedge clock) disable iff (reset)
      next_take |=> rsp_valid)
      else $error("step transaction gave no response");

   // a reseed never creates a response
   a_reseed_silent: assert property (@(posedge clock) disable iff (reset)
      (reseed_take && (!rsp_valid || rsp_ready)) |=> !rsp_valid)
      else $error("reseed transaction gave a response");

   // an empty result register never blocks requests
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty result register");

   // a stalled response holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_value)))
      else $error("stalled response changed");

endmodule

bind xorshift128_generator x128_checker u_x128_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .req_action (req_bus.action),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_value  (rsp_bus.random_value)
);
